@@ rtl/uer_pkg.sv @@
// Package: shared constants, payload types and the decimal helpers of the echo ranger.
`timescale 1ns / 1ps

package uer_pkg;

   // Echo counter and scale register
   localparam int COUNT_WIDTH = 24;
   localparam int SCALE_WIDTH = 24;
   localparam int FRAC_BITS   = 16;
   localparam int DIST_WIDTH  = 16;
   localparam int PROD_WIDTH  = COUNT_WIDTH + SCALE_WIDTH;
   localparam logic [SCALE_WIDTH-1:0] SCALE_RESET = SCALE_WIDTH'(1114112);

   // Configuration port
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam logic REG_SPEED_SCALE = 1'b0;

   // Opcodes
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_READ = 1'b1;

   // Text output
   localparam logic [DIST_WIDTH-1:0] TEXT_LIMIT = DIST_WIDTH'(45000);
   localparam logic [7:0] ASCII_ZERO = 8'h30;
   localparam logic [7:0] CH_OPEN    = 8'd91;
   localparam logic [7:0] CH_POINT   = 8'd46;
   localparam logic [7:0] CH_CLOSE   = 8'd93;

   // Character positions after the opening bracket
   localparam logic [2:0] POS_THOUSANDS = 3'd1;
   localparam logic [2:0] POS_HUNDREDS  = 3'd2;
   localparam logic [2:0] POS_TENS      = 3'd3;
   localparam logic [2:0] POS_POINT     = 3'd4;
   localparam logic [2:0] POS_UNITS     = 3'd5;
   localparam logic [2:0] POS_CLOSE     = 3'd6;

   // Reciprocal constants: exact quotients over the ranges used here
   localparam logic [16:0] RECIP_1000 = 17'd67109; // >> 26, value below 65536
   localparam int          SHIFT_1000 = 26;
   localparam logic [5:0]  RECIP_100  = 6'd41;     // >> 12, value below 1000
   localparam int          SHIFT_100  = 12;
   localparam logic [7:0]  RECIP_10   = 8'd205;    // >> 11, value below 1029
   localparam int          SHIFT_10   = 11;

   typedef struct packed {
      logic opcode;
      logic echo_level;
   } req_type;

   typedef struct packed {
      logic       trig;
      logic       measure_done;
      logic       char_valid;
      logic [7:0] char_byte;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic trig;
      logic done;
   } tick_status_type;

   typedef struct packed {
      logic       busy;
      logic [7:0] char_byte;
      logic       last;
   } text_status_type;

endpackage

@@ rtl/uer_ranger.sv @@
// Trigger, echo pulse counter and distance scaling for tick items.
`timescale 1ns / 1ps

module uer_ranger (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                tick_go,
   input  logic                                echo_level,
   input  logic [uer_pkg::SCALE_WIDTH-1:0]     speed_scale,
   output uer_pkg::tick_status_type            tick_status,
   output logic [uer_pkg::DIST_WIDTH-1:0]      distance
);

   logic [uer_pkg::COUNT_WIDTH-1:0] echo_ticks_ff, echo_ticks_in;
   logic                            armed_ff, armed_in;
   logic [uer_pkg::DIST_WIDTH-1:0]  distance_ff, distance_in;
   logic [uer_pkg::PROD_WIDTH-1:0]  product;
   logic [uer_pkg::DIST_WIDTH-1:0]  dist_calc;
   logic                            echo_end;

   assign product = {{uer_pkg::SCALE_WIDTH{1'b0}}, echo_ticks_ff}
                  * {{uer_pkg::COUNT_WIDTH{1'b0}}, speed_scale};

   // saturate anything above the distance width after the shift
   assign dist_calc = (|product[uer_pkg::PROD_WIDTH-1:uer_pkg::FRAC_BITS+uer_pkg::DIST_WIDTH])
                    ? {uer_pkg::DIST_WIDTH{1'b1}}
                    : product[uer_pkg::FRAC_BITS+uer_pkg::DIST_WIDTH-1:uer_pkg::FRAC_BITS];

   assign echo_end = !echo_level && (echo_ticks_ff != '0);

   assign tick_status.trig = !armed_ff;
   assign tick_status.done = echo_end;

   always_comb begin
      echo_ticks_in = echo_ticks_ff;
      armed_in      = armed_ff;
      distance_in   = distance_ff;
      if (tick_go) begin
         armed_in = 1'b1;
         if (echo_level) begin
            if (!(&echo_ticks_ff))
               echo_ticks_in = echo_ticks_ff + 1'b1;
         end else if (echo_end) begin
            distance_in   = dist_calc;
            echo_ticks_in = '0;
            armed_in      = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         echo_ticks_ff <= '0;
         armed_ff      <= 1'b0;
         distance_ff   <= '0;
      end else begin
         echo_ticks_ff <= echo_ticks_in;
         armed_ff      <= armed_in;
         distance_ff   <= distance_in;
      end
   end

   assign distance = distance_ff;

endmodule

@@ rtl/uer_text.sv @@
// Decimal split of the distance and the character serializer for read items.
`timescale 1ns / 1ps

module uer_text (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               step,
   input  logic [uer_pkg::DIST_WIDTH-1:0]     distance,
   output uer_pkg::text_status_type           text_status
);

   logic        busy_ff, busy_in;
   logic [2:0]  pos_ff, pos_in;
   logic [5:0]  thou_ff, thou_in;
   logic [9:0]  rem_ff, rem_in;
   logic [3:0]  hund_ff;
   logic [6:0]  rem2_ff;
   logic [3:0]  tens_ff;
   logic [3:0]  units_ff;

   logic [32:0] thou_prod;
   logic [15:0] hund_prod;
   logic [14:0] tens_prod;
   logic [3:0]  hund_calc;
   logic [6:0]  rem2_calc;
   logic [3:0]  tens_calc;
   logic [3:0]  units_calc;
   logic [7:0]  char_sel;

   // thousands part and remainder, taken when a read starts
   assign thou_prod = {17'd0, distance} * {16'd0, uer_pkg::RECIP_1000};
   assign thou_in   = thou_prod[uer_pkg::SHIFT_1000+5:uer_pkg::SHIFT_1000];
   assign rem_in    = 10'(distance - 16'(thou_in) * 16'd1000);

   // hundreds from the remainder below a thousand
   assign hund_prod = {6'd0, rem_ff} * {10'd0, uer_pkg::RECIP_100};
   assign hund_calc = hund_prod[uer_pkg::SHIFT_100+3:uer_pkg::SHIFT_100];
   assign rem2_calc = 7'(rem_ff - 10'(hund_calc) * 10'd100);

   // tens and units from the remainder below a hundred
   assign tens_prod  = {8'd0, rem2_ff} * {7'd0, uer_pkg::RECIP_10};
   assign tens_calc  = tens_prod[uer_pkg::SHIFT_10+3:uer_pkg::SHIFT_10];
   assign units_calc = 4'(rem2_ff - 7'(tens_calc) * 7'd10);

   always_comb begin
      busy_in = busy_ff;
      pos_in  = pos_ff;
      if (start) begin
         busy_in = 1'b1;
         pos_in  = uer_pkg::POS_THOUSANDS;
      end else if (step) begin
         if (pos_ff == uer_pkg::POS_CLOSE)
            busy_in = 1'b0;
         else
            pos_in = pos_ff + 3'd1;
      end
   end

   always_comb begin
      case (pos_ff)
         uer_pkg::POS_THOUSANDS: char_sel = uer_pkg::ASCII_ZERO + 8'(thou_ff);
         uer_pkg::POS_HUNDREDS:  char_sel = uer_pkg::ASCII_ZERO + 8'(hund_ff);
         uer_pkg::POS_TENS:      char_sel = uer_pkg::ASCII_ZERO + 8'(tens_ff);
         uer_pkg::POS_POINT:     char_sel = uer_pkg::CH_POINT;
         uer_pkg::POS_UNITS:     char_sel = uer_pkg::ASCII_ZERO + 8'(units_ff);
         uer_pkg::POS_CLOSE:     char_sel = uer_pkg::CH_CLOSE;
         default:                char_sel = uer_pkg::CH_CLOSE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff  <= uer_pkg::POS_THOUSANDS;
      end else begin
         busy_ff <= busy_in;
         pos_ff  <= pos_in;
      end
   end

   // digit stages advance every cycle; each is settled before its character is due
   always_ff @(posedge clock) begin
      if (start) begin
         thou_ff <= thou_in;
         rem_ff  <= rem_in;
      end
      hund_ff  <= hund_calc;
      rem2_ff  <= rem2_calc;
      tens_ff  <= tens_calc;
      units_ff <= units_calc;
   end

   assign text_status.busy      = busy_ff;
   assign text_status.char_byte = char_sel;
   assign text_status.last      = (pos_ff == uer_pkg::POS_CLOSE);

endmodule

@@ rtl/ultrasonic_echo_ranger_core.sv @@
// Top level of the ultrasonic echo ranger: channels, configuration register, result register.
//
//   channel   direction  payload        transfer when
//   req       in         uer_pkg::req_type  req_valid && !req_stall
//   rsp       out        uer_pkg::rsp_type  rsp_valid && !rsp_stall
//   csr       in/out     speed_scale    psel && penable && pwrite (pready tied high)
//
// A tick item gives one result; a new tick can be taken every cycle unless the output stalls.
// A read gives seven characters, one a cycle from the output register unless it stalls,
// so the next item waits in the input register; a read at 45000 or more gives nothing.
// An input register and the output register let one item wait while a result is stalled.
// Reset is synchronous; it clears the echo count, trigger and distance, and sets the scale
// register back to 17.0 in Q16.
`timescale 1ns / 1ps

module ultrasonic_echo_ranger_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  uer_pkg::req_type                      req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output uer_pkg::rsp_type                      rsp_data,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [uer_pkg::CSR_ADDR_WIDTH-1:0]    paddr,
   input  logic [uer_pkg::CSR_DATA_WIDTH-1:0]    pwdata,
   output logic [uer_pkg::CSR_DATA_WIDTH-1:0]    prdata,
   output logic                                  pready
);

   logic [uer_pkg::SCALE_WIDTH-1:0] scale_ff, scale_in;
   logic                            in_valid_ff, in_valid_in;
   uer_pkg::req_type                in_data_ff;
   logic                            out_valid_ff, out_valid_in;
   uer_pkg::rsp_type                out_data_ff, out_data_in;

   uer_pkg::tick_status_type        tick_status;
   uer_pkg::text_status_type        text_status;
   logic [uer_pkg::DIST_WIDTH-1:0]  distance;

   logic reg_sel;
   logic out_free;
   logic is_tick;
   logic in_range;
   logic in_go;
   logic tick_go;
   logic text_start;
   logic text_step;
   logic req_take;

   // configuration register
   assign reg_sel = (paddr[uer_pkg::CSR_ADDR_WIDTH-1] == uer_pkg::REG_SPEED_SCALE);
   assign pready  = 1'b1;
   assign prdata  = reg_sel ? uer_pkg::CSR_DATA_WIDTH'(scale_ff) : '0;

   always_comb begin
      scale_in = scale_ff;
      if (psel && penable && pwrite && pready && reg_sel)
         scale_in = pwdata[uer_pkg::SCALE_WIDTH-1:0];
   end

   // item flow
   assign out_free   = !out_valid_ff || !rsp_stall;
   assign is_tick    = (in_data_ff.opcode == uer_pkg::OP_TICK);
   assign in_range   = (distance < uer_pkg::TEXT_LIMIT);
   assign in_go      = in_valid_ff && !text_status.busy
                     && (out_free || (!is_tick && !in_range));
   assign tick_go    = in_go && is_tick;
   assign text_start = in_go && !is_tick && in_range;
   assign text_step  = text_status.busy && out_free;

   assign req_stall  = in_valid_ff && !in_go;
   assign req_take   = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take)
         in_valid_in = 1'b1;
      else if (in_go)
         in_valid_in = 1'b0;
   end

   uer_ranger u_ranger (
      .clock       (clock),
      .reset       (reset),
      .tick_go     (tick_go),
      .echo_level  (in_data_ff.echo_level),
      .speed_scale (scale_ff),
      .tick_status (tick_status),
      .distance    (distance)
   );

   uer_text u_text (
      .clock       (clock),
      .reset       (reset),
      .start       (text_start),
      .step        (text_step),
      .distance    (distance),
      .text_status (text_status)
   );

   // result register: hold while stalled, load tick results and characters
   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (out_free) begin
         out_valid_in = tick_go || text_start || text_step;
         if (text_step) begin
            out_data_in.trig         = 1'b0;
            out_data_in.measure_done = 1'b0;
            out_data_in.char_valid   = 1'b1;
            out_data_in.char_byte    = text_status.char_byte;
            out_data_in.last         = text_status.last;
         end else if (text_start) begin
            out_data_in.trig         = 1'b0;
            out_data_in.measure_done = 1'b0;
            out_data_in.char_valid   = 1'b1;
            out_data_in.char_byte    = uer_pkg::CH_OPEN;
            out_data_in.last         = 1'b0;
         end else begin
            out_data_in.trig         = tick_status.trig;
            out_data_in.measure_done = tick_status.done;
            out_data_in.char_valid   = 1'b0;
            out_data_in.char_byte    = 8'd0;
            out_data_in.last         = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff     <= uer_pkg::SCALE_RESET;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         scale_ff     <= scale_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take)
         in_data_ff <= req_data;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

@@ rtl/uer_checker.sv @@
// Port checker for the echo ranger top level, attached by bind.
`timescale 1ns / 1ps

module uer_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input uer_pkg::rsp_type rsp_data
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // characters of one read follow back to back once the previous one is taken
   a_text_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_data.char_valid && !rsp_data.last
      |=> rsp_valid && rsp_data.char_valid)
      else $error("gap or tick result inside a read's text");

   // a tick result is a single, final result with no character
   a_tick_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.char_valid |-> rsp_data.last && (rsp_data.char_byte == 8'd0))
      else $error("malformed tick result");

   // nothing is offered in the cycle after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered straight after reset");

endmodule

bind ultrasonic_echo_ranger_core uer_checker u_uer_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
